/* rtl/md5h_pkg.sv */
// md5h_pkg: shared constants, tables and helper functions for the md5 byte stream hasher
package md5h_pkg;

  // initial chaining words
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  // padding marker byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // block mode: how the message word fetch treats the buffer
  typedef logic [1:0] blk_mode_t;
  localparam blk_mode_t MODE_NORMAL   = 2'd0; // plain data block
  localparam blk_mode_t MODE_PAD_ONLY = 2'd1; // data, marker, zeros, no length
  localparam blk_mode_t MODE_PAD_LEN  = 2'd2; // data, marker, zeros, length
  localparam blk_mode_t MODE_LEN_ONLY = 2'd3; // zeros and length

  // round additive constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // rotate amounts, four per group of sixteen rounds
  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // rotate amount for a round
  function automatic logic [4:0] rot_of(logic [5:0] rnd);
    return ROT_AMT[{rnd[5:4], rnd[1:0]}];
  endfunction

  // message word index for a round
  function automatic logic [3:0] msg_index(logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] idx;
    r4 = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = r4;
      2'd1:    idx = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    idx = 4'(r4 * 4'd3 + 4'd5);
      2'd3:    idx = 4'(r4 * 4'd7);
      default: idx = r4;
    endcase
    return idx;
  endfunction

  // 32-bit left rotate by a non-zero amount
  function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  // buffer word as seen by the rounds: padding and length applied on the fly
  function automatic logic [31:0] pad_word(logic [31:0] raw, logic [3:0] widx,
                                           logic [5:0] fill, blk_mode_t mode,
                                           logic [63:0] bits);
    logic [31:0] w;
    logic [5:0]  pos;
    w = raw;
    if (mode != MODE_NORMAL) begin
      for (int b = 0; b < 4; b++) begin
        pos = {widx, 2'(b)};
        if (mode == MODE_LEN_ONLY || pos > fill) begin
          w[b*8 +: 8] = 8'h00;
        end else if (pos == fill) begin
          w[b*8 +: 8] = PAD_MARK;
        end
      end
    end
    if (mode == MODE_PAD_LEN || mode == MODE_LEN_ONLY) begin
      if (widx == 4'd14) begin
        w = bits[31:0];
      end else if (widx == 4'd15) begin
        w = bits[63:32];
      end
    end
    return w;
  endfunction

endpackage

/* rtl/md5_byte_stream_hasher_top.sv */
// md5_byte_stream_hasher_top: byte-serial md5 hasher with a single shared round unit
//
// Message bytes arrive one per item; in_tlast marks the final item of a message and
// in_tuser says whether in_tdata carries a byte (an item with in_tuser low and in_tlast
// high hashes the empty message). While the block buffer is filling, a byte is taken
// in the cycle it is offered. Every 64th byte, and the final item, starts a
// compression on the one round unit: message-word prefetch (S_LOAD0, S_LOAD1), the
// rounds (S_ROUND) and the feed-forward (S_FEED), with in_tready low all the while.
// The final item costs one or two such blocks (two when fewer than 9 bytes are left
// in the block for the marker and length) plus a load of the digest into the output
// register (S_DONE) once that register is free. The digest waits in its own
// register, so the next message may start while it is still held.
module md5_byte_stream_hasher_top (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] byte_present
  input  logic         in_tlast,   // final_byte
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // [31:0] digest_word0, [63:32] digest_word1,
                                   // [95:64] digest_word2, [127:96] digest_word3
);
  import md5h_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD0 = 3'd1;
  localparam logic [2:0] S_LOAD1 = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FEED  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [5:0]       rnd_r, rnd_nxt;
  logic [5:0]       kidx_r, kidx_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [60:0]      count_r, count_nxt;
  blk_mode_t        mode_r, mode_nxt;
  logic             pend_r, pend_nxt;
  logic [31:0]      chain_r [4];
  logic [31:0]      chain_nxt [4];
  logic [31:0]      rw_r [4];
  logic [31:0]      rw_nxt [4];
  logic [31:0]      pre_r, pre_nxt;
  logic [31:0]      km_r, km_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [127:0]     out_data_r, out_data_nxt;
  logic [3:0][7:0]  blk_r [16];

  logic             in_acc;
  logic [5:0]       fill_inc;
  logic [63:0]      bit_len;
  logic [3:0]       fetch_idx;
  logic [31:0]      fetch_word;
  logic [31:0]      f_val;
  logic [31:0]      f_sum;
  logic [31:0]      new_b;
  logic             out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign fill_inc   = fill_r + 6'(in_tuser);
  assign bit_len    = {count_r, 3'b000};

  // message word fetch for the lookahead round
  assign fetch_idx  = msg_index(kidx_r);
  assign fetch_word = pad_word(blk_r[fetch_idx], fetch_idx, fill_r, mode_r, bit_len);

  // shared round unit
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f_val = (rw_r[1] & rw_r[2]) | (~rw_r[1] & rw_r[3]);
      2'd1:    f_val = (rw_r[1] & rw_r[3]) | (rw_r[2] & ~rw_r[3]);
      2'd2:    f_val = rw_r[1] ^ rw_r[2] ^ rw_r[3];
      2'd3:    f_val = rw_r[2] ^ (rw_r[1] | ~rw_r[3]);
      default: f_val = '0;
    endcase
    f_sum = f_val + pre_r;
    new_b = rw_r[1] + rotl32(f_sum, rot_of(rnd_r));
  end

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    kidx_nxt      = kidx_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    pend_nxt      = pend_r;
    chain_nxt     = chain_r;
    rw_nxt        = rw_r;
    pre_nxt       = pre_r;
    km_nxt        = km_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    // result taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            count_nxt = count_r + 61'd1;
            fill_nxt  = fill_inc;
          end
          if (in_tuser && fill_r == 6'd63) begin
            // block full: compress, finish padding afterwards if final
            mode_nxt  = MODE_NORMAL;
            pend_nxt  = in_tlast;
            kidx_nxt  = '0;
            state_nxt = S_LOAD0;
          end else if (in_tlast) begin
            mode_nxt  = (fill_inc >= 6'd56) ? MODE_PAD_ONLY : MODE_PAD_LEN;
            kidx_nxt  = '0;
            state_nxt = S_LOAD0;
          end
        end
      end
      S_LOAD0: begin
        rw_nxt    = chain_r;
        km_nxt    = ROUND_K[kidx_r] + fetch_word;
        kidx_nxt  = kidx_r + 6'd1;
        state_nxt = S_LOAD1;
      end
      S_LOAD1: begin
        pre_nxt   = rw_r[0] + km_r;
        km_nxt    = ROUND_K[kidx_r] + fetch_word;
        kidx_nxt  = kidx_r + 6'd1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        rw_nxt[0] = rw_r[3];
        rw_nxt[1] = new_b;
        rw_nxt[2] = rw_r[1];
        rw_nxt[3] = rw_r[2];
        pre_nxt   = rw_r[3] + km_r;
        km_nxt    = ROUND_K[kidx_r] + fetch_word;
        kidx_nxt  = kidx_r + 6'd1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FEED;
        end
      end
      S_FEED: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + rw_r[i];
        end
        kidx_nxt = '0;
        if (mode_r == MODE_NORMAL) begin
          if (pend_r) begin
            // final byte filled the block: padding block follows
            pend_nxt  = 1'b0;
            mode_nxt  = MODE_PAD_LEN;
            state_nxt = S_LOAD0;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (mode_r == MODE_PAD_ONLY) begin
          mode_nxt  = MODE_LEN_ONLY;
          state_nxt = S_LOAD0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt  = {chain_r[3], chain_r[2], chain_r[1], chain_r[0]};
          out_valid_nxt = 1'b1;
          chain_nxt[0]  = IV_A;
          chain_nxt[1]  = IV_B;
          chain_nxt[2]  = IV_C;
          chain_nxt[3]  = IV_D;
          count_nxt     = '0;
          fill_nxt      = '0;
          mode_nxt      = MODE_NORMAL;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_r       <= '0;
      kidx_r      <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      mode_r      <= MODE_NORMAL;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r[0]  <= IV_A;
      chain_r[1]  <= IV_B;
      chain_r[2]  <= IV_C;
      chain_r[3]  <= IV_D;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      kidx_r      <= kidx_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rw_r       <= rw_nxt;
    pre_r      <= pre_nxt;
    km_r       <= km_nxt;
    out_data_r <= out_data_nxt;
  end

  // block buffer byte write
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser) begin
      blk_r[fill_r[5:2]][fill_r[1:0]] <= in_tdata;
    end
  end

`ifndef NO_ASSERTIONS
  // no padding work may be left over once the block is idle
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (mode_r == MODE_NORMAL && !pend_r))
    else $error("idle with padding still pending");

  // lookahead fetch runs two rounds ahead of the round unit
  a_kidx_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (kidx_r == rnd_r + 6'd2))
    else $error("message prefetch out of step with rounds");

  // rounds start at zero after the prefetch
  a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD1) |=> (state_r == S_ROUND && rnd_r == 6'd0))
    else $error("round sequence did not start at zero");

  // last round hands over to the feed-forward
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'd63) |=> (state_r == S_FEED))
    else $error("feed-forward did not follow the last round");

  // digest load always presents a result
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("digest not presented");
`endif

endmodule

/* tb/sv/tb_md5_byte_stream_hasher_top.sv */
// testbench for md5_byte_stream_hasher_top: byte messages in, digests checked against a local md5
module tb_md5_byte_stream_hasher_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one digest, word 0 in the lowest bits as on out_tdata
  typedef struct packed {
    logic [31:0] w3;
    logic [31:0] w2;
    logic [31:0] w1;
    logic [31:0] w0;
  } digest_t;

  // one stimulus row: the item and, where obvious, its digest
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       is_last;
    logic       known;
    digest_t    digest;
  } stim_row_t;

  // idling phases
  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH
  } idle_phase_t;

  localparam int ITEM_TARGET   = 1900;
  localparam int MSG_TARGET    = 20;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 150;
  localparam int MAX_REPORTS   = 10;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C   = 32'h98BADCFE;
  localparam logic [31:0] INIT_D   = 32'h10325476;

  // per-round additive constants
  localparam logic [31:0] SINE_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // rotate amounts, four per group of sixteen rounds
  localparam int ROT_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // message lengths around the block and padding boundaries
  localparam int EDGE_LENS [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  // well-known digests
  localparam digest_t EMPTY_DIGEST = '{w0: 32'hD98C1DD4, w1: 32'h04B2008F,
                                       w2: 32'h980980E9, w3: 32'h7E42F8EC};
  localparam digest_t A_DIGEST     = '{w0: 32'hB975C10C, w1: 32'hA8B6F1C0,
                                       w2: 32'hE299C331, w3: 32'h61267769};
  localparam digest_t ABC_DIGEST   = '{w0: 32'h98500190, w1: 32'hB04FD23C,
                                       w2: 32'h7D3F96D6, w3: 32'h727FE128};
  localparam digest_t NO_DIGEST    = '0;

  // directed items: data, byte present, last, digest typed in, digest
  localparam stim_row_t DIRECTED_ROWS [14] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},    // nothing at all, ignored
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}, // empty message
    '{8'h61, 1'b1, 1'b1, 1'b1, A_DIGEST},     // "a" in one item
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},   // "abc"
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST},    // data with no byte flag, ignored
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},    // end flag on an item with no byte
    '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b1, 1'b1, A_DIGEST}      // "a" closed by a bare end item
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  // typed-in digest travelling alongside the item on offer
  logic         row_known = 1'b0;
  digest_t      row_digest = '0;

  // local hash state
  logic [31:0]  chain_words [4];
  logic [31:0]  msg_words [16];
  logic [60:0]  byte_total;
  logic [5:0]   fill_pos;

  digest_t      digest_q [$];
  digest_t      pred_digest;
  digest_t      got_digest;
  digest_t      want_digest;
  int           n_bad = 0;
  int           quiet_cycles = 0;
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;

  md5_byte_stream_hasher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // start a fresh message
  function automatic void restart_hash();
    chain_words[0] = INIT_A;
    chain_words[1] = INIT_B;
    chain_words[2] = INIT_C;
    chain_words[3] = INIT_D;
    for (int i = 0; i < 16; i++) msg_words[i] = '0;
    byte_total = '0;
    fill_pos   = '0;
  endfunction

  // 64 rounds over the block, then feed-forward into the chaining words
  function automatic void absorb_block();
    logic [31:0] a, b, c, d, f, t;
    int          g, s;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = f + a + SINE_K[r] + msg_words[g];
      s = ROT_S[(r / 16) * 4 + r % 4];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain_words[0] = chain_words[0] + a;
    chain_words[1] = chain_words[1] + b;
    chain_words[2] = chain_words[2] + c;
    chain_words[3] = chain_words[3] + d;
  endfunction

  // take one item; returns 1 with the digest when the message closes
  function automatic logic hash_step(input logic [7:0] data_v, input logic present,
                                     input logic is_last, output digest_t dig);
    logic [63:0] bit_len;
    dig = '0;
    if (present) begin
      msg_words[fill_pos[5:2]][fill_pos[1:0] * 8 +: 8] = data_v;
      byte_total = byte_total + 1'b1;
      fill_pos   = fill_pos + 1'b1;
      if (fill_pos == 6'd0) absorb_block();
    end
    if (!is_last) return 1'b0;
    // marker byte, zeros, and a spill block when the length no longer fits
    msg_words[fill_pos[5:2]][fill_pos[1:0] * 8 +: 8] = PAD_BYTE;
    for (int p = fill_pos + 1; p < 64; p++) msg_words[p / 4][(p % 4) * 8 +: 8] = 8'h00;
    if (fill_pos >= 6'd56) begin
      absorb_block();
      for (int i = 0; i < 16; i++) msg_words[i] = '0;
    end
    bit_len = {byte_total, 3'b000};
    msg_words[14] = bit_len[31:0];
    msg_words[15] = bit_len[63:32];
    absorb_block();
    dig.w0 = chain_words[0];
    dig.w1 = chain_words[1];
    dig.w2 = chain_words[2];
    dig.w3 = chain_words[3];
    restart_hash();
    return 1'b1;
  endfunction

  // predict on accepted items, check accepted digests
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (hash_step(in_tdata, in_tuser, in_tlast, pred_digest)) begin
          digest_q.push_back(row_known ? row_digest : pred_digest);
        end
      end
      if (out_tvalid && out_tready) begin
        got_digest = out_tdata;
        if (digest_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) $display("unexpected digest %h", got_digest);
        end else begin
          want_digest = digest_q.pop_front();
          if (got_digest.w0 !== want_digest.w0 || got_digest.w1 !== want_digest.w1 ||
              got_digest.w2 !== want_digest.w2 || got_digest.w3 !== want_digest.w3) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS) begin
              $display("digest mismatch: expected %h %h %h %h, got %h %h %h %h",
                       want_digest.w0, want_digest.w1, want_digest.w2, want_digest.w3,
                       got_digest.w0, got_digest.w1, got_digest.w2, got_digest.w3);
            end
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offer one item after random idle cycles and hold it until taken
  task automatic send_item(input logic [7:0] d, input logic p, input logic l,
                           input logic known, input digest_t dg);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= d;
    in_tuser   <= p;
    in_tlast   <= l;
    row_known  <= known;
    row_digest <= dg;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off the sender until every digest has come out
  task automatic drain_digests();
    in_tvalid <= 1'b0;
    // let the last accepted item be predicted before the queue is checked
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // switch idling pattern on both sides
  task automatic set_phase(input idle_phase_t ph);
    case (ph)
      PH_STEADY: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      PH_SENDER_IDLE: begin
        sender_idle_pct    = 62;
        receiver_stall_pct = 0;
      end
      PH_RECEIVER_STALL: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 62;
      end
      default: begin
        sender_idle_pct    = 29;
        receiver_stall_pct = 29;
      end
    endcase
  endtask

  // stimulus
  initial begin
    int          n_items;
    int          n_msgs;
    int          len;
    int          pick;
    logic        bare_end;
    idle_phase_t ph;
    n_items = 0;
    n_msgs  = 0;
    restart_hash();
    set_phase(PH_STEADY);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (DIRECTED_ROWS[i]) begin
      send_item(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].present, DIRECTED_ROWS[i].is_last,
                DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].digest);
    end

    // random messages, idling pattern changing every five
    while (n_items < ITEM_TARGET || n_msgs < MSG_TARGET) begin
      if (n_msgs % 5 == 0) begin
        drain_digests();
        ph = idle_phase_t'((n_msgs / 5) % 4);
        set_phase(ph);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        len = $urandom_range(0, 20);
      end else if (pick < 7) begin
        len = EDGE_LENS[$urandom_range(0, 11)];
      end else if (pick < 9) begin
        len = $urandom_range(21, 140);
      end else begin
        len = $urandom_range(150, 300);
      end
      bare_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
          n_items++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, !bare_end && (i == len - 1),
                  1'b0, NO_DIGEST);
        n_items++;
      end
      if (bare_end) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
        n_items++;
      end
      n_msgs++;
    end

    // wind down
    drain_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_bad == 0 && digest_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
